[hw/rtl/ils_pkg.sv]
// Shared types and codes for the indexed list store.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

    typedef enum logic [2:0] {
        CMD_GET      = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_INS_AT   = 3'd3,
        CMD_DELETE   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell for one accepted command.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/ils_cell.sv]
// One storage cell of the list: holds one entry and moves it to or from its neighbors.
// Depends on ils_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module ils_cell #(
    parameter int VALUE_BITS = 16,
    parameter int CW         = 9,
    parameter int IDX        = 0
) (
    input  wire logic                  clk,
    input  wire ils_pkg::cell_ctrl_t   ctrl,
    input  wire logic [CW-1:0]         at,
    input  wire logic [VALUE_BITS-1:0] new_value,
    input  wire logic [VALUE_BITS-1:0] left_value,
    input  wire logic [VALUE_BITS-1:0] right_value,
    output logic      [VALUE_BITS-1:0] cell_value
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (MY_IDX == at)
                value_next = new_value;
            else if (MY_IDX > at)
                value_next = left_value;
        end
        else if (ctrl.del)
        begin
            if (MY_IDX >= at)
                value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign cell_value = value_reg;

endmodule

`default_nettype wire

[hw/rtl/indexed_list_store.sv]
// Indexed list store top level: command decode, length counter, row of cells, result register.
// Depends on ils_pkg and ils_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, position and value.
//   Output channel (out_valid/out_ready) carries read_value, read_valid,
//   status and length; every command gives exactly one result.
//   A command is decoded and applied to the row of cells in the cycle of its
//   transfer; all cells shift up or down at the addressed position at once.
//   The result sits in an output register and is offered in the cycle after the
//   input transfer.
//   Throughput is one command per cycle while the receiver takes every result.
//   in_ready is high whenever the output register is empty or is being taken
//   in the same cycle; a stalled receiver holds the result and stops input.
//   Reset empties the list (length 0) and clears the output valid flag; the
//   result fields and the entry storage itself are not cleared, and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_store #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 16,
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [2:0]            command,
    input  wire logic [CW-1:0]         position,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [VALUE_BITS-1:0] read_value,
    output logic                       read_valid,
    output logic      [1:0]            status,
    output logic      [CW-1:0]         length
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic                  read_valid_reg;
    logic [1:0]            status_reg;
    logic [CW-1:0]         length_reg;

    logic [VALUE_BITS-1:0] cell_q [CAPACITY];
    ils_pkg::cell_ctrl_t   ctrl;
    ils_pkg::cell_ctrl_t   op;
    logic [CW-1:0]         at;
    logic [VALUE_BITS-1:0] rv;
    logic                  rvalid;
    ils_pkg::status_t      st;
    logic                  accept;
    logic                  full;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CAP);

    always_comb
    begin
        op     = '0;
        at     = '0;
        rv     = '0;
        rvalid = 1'b0;
        st     = ils_pkg::ST_DONE;
        case (command)
            ils_pkg::CMD_GET:
            begin
                if (position < count_reg)
                begin
                    rv     = cell_q[position[IW-1:0]];
                    rvalid = 1'b1;
                end
                else
                    st = ils_pkg::ST_RANGE;
            end
            ils_pkg::CMD_INS_HEAD:
            begin
                if (full)
                    st = ils_pkg::ST_FULL;
                else
                    op.ins = 1'b1;
            end
            ils_pkg::CMD_INS_TAIL:
            begin
                at = count_reg;
                if (full)
                    st = ils_pkg::ST_FULL;
                else
                    op.ins = 1'b1;
            end
            ils_pkg::CMD_INS_AT:
            begin
                at = position;
                if (position > count_reg)
                    st = ils_pkg::ST_RANGE;
                else if (full)
                    st = ils_pkg::ST_FULL;
                else
                    op.ins = 1'b1;
            end
            ils_pkg::CMD_DELETE:
            begin
                at = position;
                if (position >= count_reg)
                    st = ils_pkg::ST_RANGE;
                else
                    op.del = 1'b1;
            end
            default:
            begin
                op = '0;
            end
        endcase
    end

    always_comb
    begin
        ctrl       = accept ? op : '0;
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CW'(1);
        else if (ctrl.del)
            count_next = count_reg - CW'(1);
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] left_value;
        logic [VALUE_BITS-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_mid_l
            assign left_value = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_mid_r
            assign right_value = cell_q[i+1];
        end

        ils_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CW         (CW),
            .IDX        (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .at          (at),
            .new_value   (value),
            .left_value  (left_value),
            .right_value (right_value),
            .cell_value  (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= rv;
            read_valid_reg <= rvalid;
            status_reg     <= st;
            length_reg     <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign read_valid = read_valid_reg;
    assign status     = status_reg;
    assign length     = length_reg;

endmodule

`default_nettype wire

[hw/rtl/ils_checker.sv]
// Port-level checks for indexed_list_store, attached by the bind at the end of this file.
// Depends on ils_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none

module ils_checker #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 16,
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [VALUE_BITS-1:0] read_value,
    input wire logic                  read_valid,
    input wire logic [1:0]            status,
    input wire logic [CW-1:0]         length
);

    a_read_ok : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> status == ils_pkg::ST_DONE)
        else $error("read_valid with non-done status");

    a_len_cap : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length <= CW'(CAPACITY))
        else $error("length above capacity");

    a_stall_only : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after input transfer");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value)
            && $stable(status) && $stable(length))
        else $error("stalled result changed");

endmodule

bind indexed_list_store ils_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
) u_ils_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .read_valid (read_valid),
    .status     (status),
    .length     (length)
);

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for indexed_list_store: directed edge cases, then phased random traffic.
// A scoreboard class predicts every result; depends on ils_pkg and the indexed_list_store RTL.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH          = 256;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 230;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED    = 40;

    class list_scoreboard;
        typedef struct packed {
            logic [15:0] rd_value;
            logic        rd_valid;
            logic [1:0]  st;
            logic [8:0]  len;
        } outcome_t;

        logic [15:0] cells [DEPTH];
        int          fill;
        outcome_t    due [$];
        int          errors;
        int          checked;
        int          full_rejects;
        int          range_rejects;
        int          peak;

        function new();
            fill          = 0;
            errors        = 0;
            checked       = 0;
            full_rejects  = 0;
            range_rejects = 0;
            peak          = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function void note_input(logic [2:0] cmd, logic [8:0] pos, logic [15:0] val);
            outcome_t o;
            int       at;
            int       i;
            o  = '0;
            at = 0;
            case (cmd)
                ils_pkg::CMD_GET:
                    if (pos < fill)
                    begin
                        o.rd_value = cells[pos];
                        o.rd_valid = 1'b1;
                    end
                    else
                        o.st = ils_pkg::ST_RANGE;
                ils_pkg::CMD_INS_HEAD, ils_pkg::CMD_INS_TAIL, ils_pkg::CMD_INS_AT:
                    if (cmd == ils_pkg::CMD_INS_AT && pos > fill)
                        o.st = ils_pkg::ST_RANGE;
                    else if (fill >= DEPTH)
                        o.st = ils_pkg::ST_FULL;
                    else
                    begin
                        if (cmd == ils_pkg::CMD_INS_HEAD)
                            at = 0;
                        else if (cmd == ils_pkg::CMD_INS_TAIL)
                            at = fill;
                        else
                            at = pos;
                        for (i = fill; i > at; i--)
                            cells[i] = cells[i - 1];
                        cells[at] = val;
                        fill++;
                    end
                ils_pkg::CMD_DELETE:
                    if (pos >= fill)
                        o.st = ils_pkg::ST_RANGE;
                    else
                    begin
                        for (i = pos; i + 1 < fill; i++)
                            cells[i] = cells[i + 1];
                        fill--;
                    end
                default: ;  // unknown command: no effect
            endcase
            if (o.st == ils_pkg::ST_FULL)
                full_rejects++;
            if (o.st == ils_pkg::ST_RANGE)
                range_rejects++;
            if (fill > peak)
                peak = fill;
            o.len = fill[8:0];
            due.push_back(o);
        endfunction

        task check_result(logic [15:0] rv, logic rvld, logic [1:0] st, logic [8:0] len);
            outcome_t o;
            if (due.size() == 0)
            begin
                report($sformatf("result with nothing outstanding (len %0d)", len));
            end
            else
            begin
                o = due.pop_front();
                checked++;
                if (rv !== o.rd_value)
                    report($sformatf("read_value %h, want %h", rv, o.rd_value));
                if (rvld !== o.rd_valid)
                    report($sformatf("read_valid %b, want %b", rvld, o.rd_valid));
                if (st !== o.st)
                    report($sformatf("status %0d, want %0d", st, o.st));
                if (len !== o.len)
                    report($sformatf("length %0d, want %0d", len, o.len));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [2:0]  command   = '0;
    logic [8:0]  position  = '0;
    logic [15:0] value     = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [15:0] read_value;
    logic        read_valid;
    logic [1:0]  status;
    logic [8:0]  length;

    list_scoreboard sb;
    int tx_pct     = 0;
    int rx_pct     = 0;
    bit long_hold  = 1'b0;
    int items_sent = 0;

    indexed_list_store u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .read_valid (read_valid),
        .status     (status),
        .length     (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls per phase, plus one long hold-off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            out_ready <= (rx_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= rx_pct);
        end
    end

    // Results are sampled mid-cycle; the transfer completes at the next edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(read_value, read_valid, status, length);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet, sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(logic [2:0] c, logic [8:0] p, logic [15:0] v);
        int   gap;
        logic took;
        gap = 0;
        while (tx_pct != 0 && gap < 30 && $urandom_range(0, 99) < tx_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        position <= p;
        value    <= v;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        sb.note_input(c, p, v);
        items_sent++;
    endtask

    task automatic random_item(int ins_pct, int del_pct);
        int          r;
        logic [2:0]  c;
        logic [8:0]  p;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 3)
            c = 3'($urandom_range(5, 7));
        else if (r < 3 + ins_pct)
            c = 3'($urandom_range(ils_pkg::CMD_INS_HEAD, ils_pkg::CMD_INS_AT));
        else if (r < 3 + ins_pct + del_pct)
            c = ils_pkg::CMD_DELETE;
        else
            c = ils_pkg::CMD_GET;

        r = $urandom_range(0, 99);
        if (r < 12 || c == ils_pkg::CMD_INS_HEAD || c == ils_pkg::CMD_INS_TAIL)
            p = 9'($urandom_range(0, 511));
        else if (c == ils_pkg::CMD_INS_AT)
            p = (r < 17) ? 9'(sb.fill + 1) : 9'($urandom_range(0, sb.fill));
        else if (sb.fill == 0 || r < 17)
            p = 9'(sb.fill);
        else
            p = 9'($urandom_range(0, sb.fill - 1));

        r = $urandom_range(0, 99);
        if (r < 10)
            v = 16'h0000;
        else if (r < 20)
            v = 16'hFFFF;
        else
            v = 16'($urandom_range(0, 65535));
        send_item(c, p, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic directed_items();
        send_item(ils_pkg::CMD_GET,      9'd0,   16'hFFFF);   // get on empty list
        send_item(ils_pkg::CMD_DELETE,   9'd0,   16'hFFFF);   // delete on empty list
        send_item(ils_pkg::CMD_INS_AT,   9'd1,   16'h5555);   // insert past end
        send_item(ils_pkg::CMD_INS_AT,   9'd0,   16'h1234);
        send_item(ils_pkg::CMD_INS_HEAD, 9'd511, 16'hFFFF);
        send_item(ils_pkg::CMD_INS_TAIL, 9'd0,   16'h0000);
        send_item(ils_pkg::CMD_INS_AT,   9'd3,   16'h00FF);   // insert at end position
        send_item(ils_pkg::CMD_INS_AT,   9'd1,   16'hA5A5);
        send_item(ils_pkg::CMD_GET,      9'd0,   16'h0000);
        send_item(ils_pkg::CMD_GET,      9'd4,   16'h0000);
        send_item(ils_pkg::CMD_GET,      9'd5,   16'h0000);   // one past last entry
        send_item(ils_pkg::CMD_GET,      9'd511, 16'h0000);
        send_item(ils_pkg::CMD_GET,      9'd256, 16'h0000);
        send_item(ils_pkg::CMD_INS_AT,   9'd511, 16'h7777);
        send_item(ils_pkg::CMD_DELETE,   9'd511, 16'h0000);
        send_item(3'd5,                  9'd511, 16'hFFFF);   // unknown commands
        send_item(3'd6,                  9'd0,   16'h0000);
        send_item(3'd7,                  9'd2,   16'hFFFF);
        send_item(ils_pkg::CMD_DELETE,   9'd4,   16'h0000);   // tail
        send_item(ils_pkg::CMD_DELETE,   9'd0,   16'h0000);   // head
        send_item(ils_pkg::CMD_DELETE,   9'd1,   16'h0000);
        send_item(ils_pkg::CMD_GET,      9'd1,   16'h0000);
    endtask

    initial
    begin
        int ph;
        int k;
        int ins_mix [PHASES] = '{40, 75, 75, 60, 10, 10, 45, 75};
        int del_mix [PHASES] = '{30, 10, 10, 10, 75, 75, 35, 10};
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 46; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 46; end
                default: begin tx_pct = 34; rx_pct = 34; end
            endcase
            if (ph == 1)
                long_hold = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                random_item(ins_mix[ph], del_mix[ph]);
            drain();
        end

        repeat (20) @(posedge clk);
        $display("run: %0d commands, %0d results checked, peak length %0d",
                 items_sent, sb.checked, sb.peak);
        $display("rejects: %0d full, %0d out of range; %0d mismatches",
                 sb.full_rejects, sb.range_rejects, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
